/* rtl/pcc_pkg.sv */
package pcc_pkg;

	localparam int COORD_WIDTH     = 24;
	localparam int UP_WIDTH        = 16;
	localparam int QUEUE_DEPTH     = 4;
	localparam int MUL_CHUNK       = 17;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int UP_Z_RESET      = 16384;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP_X = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP_Y = CFG_INDEX_WIDTH'(1);
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP_Z = CFG_INDEX_WIDTH'(2);

	typedef logic signed [1:0] sign_t;

	localparam sign_t SIGN_NONE = 2'sb00;
	localparam sign_t SIGN_POS  = 2'sb01;
	localparam sign_t SIGN_NEG  = 2'sb11;

	typedef struct packed {
		logic  degen;
		logic  restart;
		sign_t sgn;
	} cls_t;

endpackage

/* rtl/pcc_if.sv */
interface pcc_vtx_if #(
	parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] a_x;
	logic signed [COORD_WIDTH-1:0] a_y;
	logic signed [COORD_WIDTH-1:0] a_z;
	logic signed [COORD_WIDTH-1:0] b_x;
	logic signed [COORD_WIDTH-1:0] b_y;
	logic signed [COORD_WIDTH-1:0] b_z;
	logic signed [COORD_WIDTH-1:0] c_x;
	logic signed [COORD_WIDTH-1:0] c_y;
	logic signed [COORD_WIDTH-1:0] c_z;
	logic                          restart;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, restart,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, restart,
		output ready
	);
endinterface

interface pcc_res_if;
	logic           valid;
	logic           ready;
	logic           is_convex;
	pcc_pkg::sign_t winding_sign;

	modport source (output valid, is_convex, winding_sign, input ready);
	modport sink (input valid, is_convex, winding_sign, output ready);
endinterface

interface pcc_cfg_if #(
	parameter int UP_WIDTH = pcc_pkg::UP_WIDTH
);
	logic                                valid;
	logic                                ready;
	logic [pcc_pkg::CFG_INDEX_WIDTH-1:0] index;
	logic [UP_WIDTH-1:0]                 data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pcc_mul.sv */
module pcc_mul #(
	parameter int AW = 25,
	parameter int BW = 25
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a,
	input  logic signed [BW-1:0] b,
	output logic signed [AW+BW-1:0] p
);

	localparam int CH = pcc_pkg::MUL_CHUNK;
	localparam int NA = (AW + CH - 1) / CH;
	localparam int NB = (BW + CH - 1) / CH;
	localparam int SW = (NA + NB) * CH + 2;

	logic signed [NA*CH-1:0]   a_ext;
	logic signed [NB*CH-1:0]   b_ext;
	logic signed [CH:0]        ca [NA];
	logic signed [CH:0]        cb [NB];
	logic signed [2*CH+1:0]    pp_s1 [NA*NB];
	logic signed [SW-1:0]      acc;
	logic signed [AW+BW-1:0]   p_s2;

	assign a_ext = (NA*CH)'(a);
	assign b_ext = (NB*CH)'(b);

	for (genvar gi = 0; gi < NA; gi++) begin : g_ca
		if (gi == NA - 1) begin : g_top
			assign ca[gi] = $signed({a_ext[gi*CH+CH-1], a_ext[gi*CH +: CH]});
		end else begin : g_low
			assign ca[gi] = $signed({1'b0, a_ext[gi*CH +: CH]});
		end
	end

	for (genvar gj = 0; gj < NB; gj++) begin : g_cb
		if (gj == NB - 1) begin : g_top
			assign cb[gj] = $signed({b_ext[gj*CH+CH-1], b_ext[gj*CH +: CH]});
		end else begin : g_low
			assign cb[gj] = $signed({1'b0, b_ext[gj*CH +: CH]});
		end
	end

	for (genvar gi = 0; gi < NA; gi++) begin : g_pp_a
		for (genvar gj = 0; gj < NB; gj++) begin : g_pp_b
			always_ff @(posedge clk) begin
				if (en) begin
					pp_s1[gi*NB+gj] <= ca[gi] * cb[gj];
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (SW'(pp_s1[i*NB+j]) <<< ((i + j) * CH));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= $signed(acc[AW+BW-1:0]);
		end
	end

	assign p = p_s2;

endmodule

/* rtl/pcc_front.sv */
module pcc_front #(
	parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH,
	parameter int UP_WIDTH    = pcc_pkg::UP_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pcc_vtx_if.sink                    vtx,
	input  logic signed [UP_WIDTH-1:0] up_x,
	input  logic signed [UP_WIDTH-1:0] up_y,
	input  logic signed [UP_WIDTH-1:0] up_z,
	output logic                       q_wr_en,
	output pcc_pkg::cls_t              q_wr_data,
	input  logic                       q_wr_ready
);

	localparam int DW  = COORD_WIDTH + 1;
	localparam int PW  = 2 * DW;
	localparam int XW  = PW + 1;
	localparam int TW  = XW + UP_WIDTH;
	localparam int SUW = TW + 2;

	typedef struct packed {
		logic vld;
		logic degen;
		logic restart;
	} side_t;

	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	pcc_pkg::sign_t sgn_s7;

	logic                       en;
	logic signed [DW-1:0]       u_s1 [3];
	logic signed [DW-1:0]       v_s1 [3];
	logic signed [PW-1:0]       pa_s3 [3];
	logic signed [PW-1:0]       pb_s3 [3];
	logic signed [XW-1:0]       cr_s4 [3];
	logic signed [TW-1:0]       dt_s6 [3];
	logic signed [UP_WIDTH-1:0] up [3];
	logic signed [SUW-1:0]      dot;
	logic                       degen;
	pcc_pkg::sign_t             sgn;

	assign en        = !side_s7.vld || q_wr_ready;
	assign vtx.ready = en;
	assign q_wr_en   = side_s7.vld && q_wr_ready;
	assign q_wr_data = '{degen: side_s7.degen, restart: side_s7.restart, sgn: sgn_s7};

	assign up[0] = up_x;
	assign up[1] = up_y;
	assign up[2] = up_z;

	assign degen = (vtx.a_x == vtx.c_x) && (vtx.a_y == vtx.c_y) && (vtx.a_z == vtx.c_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
		end else if (en) begin
			side_s1 <= '{vld: vtx.valid, degen: degen, restart: vtx.restart};
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1[0] <= DW'(vtx.a_x) - DW'(vtx.b_x);
			u_s1[1] <= DW'(vtx.a_y) - DW'(vtx.b_y);
			u_s1[2] <= DW'(vtx.a_z) - DW'(vtx.b_z);
			v_s1[0] <= DW'(vtx.c_x) - DW'(vtx.a_x);
			v_s1[1] <= DW'(vtx.c_y) - DW'(vtx.a_y);
			v_s1[2] <= DW'(vtx.c_z) - DW'(vtx.a_z);
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_axis
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;

		pcc_mul #(.AW(DW), .BW(DW)) u_mul_a (
			.clk (clk),
			.en  (en),
			.a   (u_s1[K1]),
			.b   (v_s1[K2]),
			.p   (pa_s3[k])
		);

		pcc_mul #(.AW(DW), .BW(DW)) u_mul_b (
			.clk (clk),
			.en  (en),
			.a   (u_s1[K2]),
			.b   (v_s1[K1]),
			.p   (pb_s3[k])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				cr_s4[k] <= XW'(pa_s3[k]) - XW'(pb_s3[k]);
			end
		end

		pcc_mul #(.AW(XW), .BW(UP_WIDTH)) u_mul_up (
			.clk (clk),
			.en  (en),
			.a   (cr_s4[k]),
			.b   (up[k]),
			.p   (dt_s6[k])
		);
	end

	assign dot = SUW'(dt_s6[0]) + SUW'(dt_s6[1]) + SUW'(dt_s6[2]);

	always_comb begin
		priority if (dot[SUW-1]) begin
			sgn = pcc_pkg::SIGN_NEG;
		end else if (dot != '0) begin
			sgn = pcc_pkg::SIGN_POS;
		end else begin
			sgn = pcc_pkg::SIGN_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s7 <= sgn;
		end
	end

endmodule

/* rtl/pcc_queue.sv */
module pcc_queue #(
	parameter int DEPTH = pcc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  pcc_pkg::cls_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output pcc_pkg::cls_t rd_data,
	output logic          empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pcc_pkg::cls_t   mem [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW-1:0]   rd_ptr_nxt;
	logic [CW-1:0]   count_q;
	pcc_pkg::cls_t   rd_data_q;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = rd_data_q;

	always_comb begin
		rd_ptr_nxt = rd_ptr_q;
		if (rd_en) begin
			rd_ptr_nxt = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	// The head entry is kept in a register, with a request written into the head slot
	// passed straight through.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_ptr_q == rd_ptr_nxt)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_ptr_nxt];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			rd_ptr_q <= rd_ptr_nxt;
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/pcc_back.sv */
module pcc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  pcc_pkg::cls_t q_data,
	output logic          q_rd_en,
	pcc_res_if.source     res
);

	logic           out_vld_q;
	logic           convex_q;
	pcc_pkg::sign_t sign_q;
	logic           conv_nxt;
	pcc_pkg::sign_t sign_nxt;

	assign q_rd_en          = !q_empty && (!out_vld_q || res.ready);
	assign res.valid        = out_vld_q;
	assign res.is_convex    = convex_q;
	assign res.winding_sign = sign_q;

	always_comb begin
		conv_nxt = q_data.restart ? 1'b1 : convex_q;
		sign_nxt = q_data.restart ? pcc_pkg::SIGN_NONE : sign_q;
		if (conv_nxt) begin
			priority if (q_data.degen) begin
				conv_nxt = 1'b0;
			end else if (q_data.sgn == pcc_pkg::SIGN_NONE) begin
				conv_nxt = 1'b1;
			end else if (sign_nxt == pcc_pkg::SIGN_NONE) begin
				sign_nxt = q_data.sgn;
			end else begin
				conv_nxt = (sign_nxt == q_data.sgn);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			convex_q  <= 1'b1;
			sign_q    <= pcc_pkg::SIGN_NONE;
		end else begin
			if (q_rd_en) begin
				out_vld_q <= 1'b1;
				convex_q  <= conv_nxt;
				sign_q    <= sign_nxt;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/polygon_convexity_checker.sv */
// One request carries a vertex triple A, B, C; the block forms the exact sign of
// ((A - B) x (C - A)) . up against the up vector held in registers 0 to 2 and returns,
// for every request, the convex flag and the stored winding sign after that triple.
// Requests are taken one per cycle unless the queue is full and the seven-stage
// arithmetic front end stalls with a result in its last stage; the state update at
// the back drains the small queue. A result passes the front-end stages, the queue
// head and output registers. The restart bit starts a new polygon. Configuration
// writes are always accepted and should be made only while no request is in flight.
module polygon_convexity_checker #(
	parameter int COORD_WIDTH = pcc_pkg::COORD_WIDTH,
	parameter int UP_WIDTH    = pcc_pkg::UP_WIDTH,
	parameter int QUEUE_DEPTH = pcc_pkg::QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	pcc_vtx_if.sink   vtx,
	pcc_res_if.source res,
	pcc_cfg_if.sink   cfg
);

	logic signed [UP_WIDTH-1:0] up_x_q;
	logic signed [UP_WIDTH-1:0] up_y_q;
	logic signed [UP_WIDTH-1:0] up_z_q;
	logic                       q_wr_en;
	logic                       q_full;
	logic                       q_rd_en;
	logic                       q_empty;
	pcc_pkg::cls_t              q_wr_data;
	pcc_pkg::cls_t              q_rd_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_x_q <= '0;
			up_y_q <= '0;
			up_z_q <= UP_WIDTH'(pcc_pkg::UP_Z_RESET);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pcc_pkg::REG_UP_X: up_x_q <= $signed(cfg.data);
				pcc_pkg::REG_UP_Y: up_y_q <= $signed(cfg.data);
				pcc_pkg::REG_UP_Z: up_z_q <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	pcc_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.UP_WIDTH    (UP_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vtx        (vtx),
		.up_x       (up_x_q),
		.up_y       (up_y_q),
		.up_z       (up_z_q),
		.q_wr_en    (q_wr_en),
		.q_wr_data  (q_wr_data),
		.q_wr_ready (!q_full)
	);

	pcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_rd_en),
		.rd_data (q_rd_data),
		.empty   (q_empty)
	);

	pcc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rd_data),
		.q_rd_en (q_rd_en),
		.res     (res)
	);

endmodule
